// File: rtl/core/mmucid_pkg.sv
// Shared types, constants and helper functions of the MMU context id allocator.
// Depends on nothing; the bitmap RAM and the top level import it.
package mmucid_pkg;

  localparam int NUM_CONTEXTS = 256;
  // Bits per bitmap word; a power of two, so word and bit come from shifts and masks.
  localparam int WORD_BITS    = 32;
  localparam int NUM_WORDS    = (NUM_CONTEXTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int CNT_W        = $clog2(NUM_CONTEXTS + 1);
  localparam int ID_W         = 8;
  localparam int SHARED_CTX   = NUM_CONTEXTS - 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WIDX_W-1:0]    widx_t;
  typedef logic [BIT_W-1:0]     bidx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] context_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic            got_shared;
    logic [ID_W-1:0] free_count;
  } out_item_t;

  // Write request from the sequencer to the bitmap RAM.
  typedef struct packed {
    logic  en;
    widx_t addr;
    word_t data;
  } mem_wr_t;

  // Bitmap word after reset: every context free except the shared one and
  // any bit position beyond the last context.
  function automatic word_t reset_word(widx_t w);
    word_t r;
    int    c;
    r = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      c = int'(w) * WORD_BITS + b;
      if (c < SHARED_CTX) begin
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // Position of the lowest set bit; the word is known to be non-zero.
  function automatic bidx_t lowest_bit(word_t x);
    word_t onehot;
    bidx_t r;
    onehot = x & (~x + word_t'(1));
    r      = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (onehot[b]) begin
        r = r | bidx_t'(b);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/mmucid_bitmap_ram.sv
// Free bitmap storage: one write port, one read port with a registered read.
// Entries never written read back as their reset pattern. Uses mmucid_pkg.
module mmucid_bitmap_ram
  import mmucid_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  widx_t   rd_addr,
  output word_t   rd_data,
  input  mem_wr_t wr
);

  word_t                mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  word_t                rd_q_r;
  widx_t                rd_addr_q_r;
  logic                 rd_valid_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r       <= mem[rd_addr];
      rd_addr_q_r  <= rd_addr;
      rd_valid_q_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_valid_q_r ? rd_q_r : reset_word(rd_addr_q_r);

endmodule

// File: rtl/core/mmu_context_id_allocator.sv
// MMU context id allocator: a bitmap of free context numbers in a small RAM.
// Allocate: the first bitmap word is read on the accepting edge; the scan then checks
// one bitmap word per cycle until it finds a free bit or reaches the last word.
// Free: one read, then one conditional write. The next transaction is accepted the
// cycle after a result is placed in the output register; a result parked behind
// a stalled output keeps the input stalled until it moves.
// Reset: synchronous, active low; every context but the shared one is free.
module mmu_context_id_allocator
  import mmucid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // The sequencer walks the RAM one word per cycle. In SCAN the word read in
  // the previous cycle is checked while the next one is being read. HOLD keeps
  // a finished result when the output register is still occupied by an untaken
  // transaction.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_CHK,
    ST_HOLD
  } state_t;

  state_t          state_r, state_nxt;
  widx_t           chk_r, chk_nxt;
  cnt_t            cnt_r, cnt_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  out_item_t       pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            rd_en;
  widx_t           rd_addr;
  word_t           rd_data;
  mem_wr_t         wr;

  logic            done;
  out_item_t       res;
  logic            slot_free;
  logic            load_out;
  bidx_t           fbit;
  bidx_t           id_bit;
  logic            id_ok;

  mmucid_bitmap_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // The output register can take a new result when it is empty or its
  // current transaction completes in this cycle.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  assign fbit   = lowest_bit(rd_data);
  assign id_bit = id_r[BIT_W-1:0];
  // Only ids that name a real, non-shared context change the bitmap.
  assign id_ok  = (int'(id_r) < NUM_CONTEXTS) && (int'(id_r) != SHARED_CTX);

  always_comb begin
    state_nxt     = state_r;
    chk_nxt       = chk_r;
    cnt_nxt       = cnt_r;
    id_nxt        = id_r;
    pend_nxt      = pend_r;
    rd_en         = 1'b0;
    rd_addr       = chk_r;
    wr            = '0;
    done          = 1'b0;
    res           = pend_r;
    load_out      = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rd_en  = 1'b1;
          id_nxt = in_data.context_id;
          if (in_data.kind == KIND_ALLOC) begin
            rd_addr   = '0;
            chk_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            rd_addr   = widx_t'(in_data.context_id >> BIT_W);
            state_nxt = ST_FREE_CHK;
          end
        end
      end

      ST_SCAN: begin
        if (rd_data != '0) begin
          wr.en   = 1'b1;
          wr.addr = chk_r;
          wr.data = rd_data & ~(word_t'(1) << fbit);
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - cnt_t'(1);
          end
          res.granted_id = ID_W'({chk_r, fbit});
          res.got_shared = 1'b0;
          res.free_count = ID_W'(cnt_nxt);
          done           = 1'b1;
        end else if (chk_r == widx_t'(NUM_WORDS - 1)) begin
          // Nothing free anywhere: hand out the shared context.
          res.granted_id = ID_W'(SHARED_CTX);
          res.got_shared = 1'b1;
          res.free_count = ID_W'(cnt_r);
          done           = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = chk_r + widx_t'(1);
          chk_nxt = chk_r + widx_t'(1);
        end
      end

      ST_FREE_CHK: begin
        // A context that is already free leaves the count alone.
        if (id_ok && !rd_data[id_bit]) begin
          wr.en   = 1'b1;
          wr.addr = widx_t'(id_r >> BIT_W);
          wr.data = rd_data | (word_t'(1) << id_bit);
          cnt_nxt = cnt_r + cnt_t'(1);
        end
        res.granted_id = id_r;
        res.got_shared = 1'b0;
        res.free_count = ID_W'(cnt_nxt);
        done           = 1'b1;
      end

      ST_HOLD: begin
        if (slot_free) begin
          load_out     = 1'b1;
          out_data_nxt = pend_r;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      if (slot_free) begin
        load_out     = 1'b1;
        out_data_nxt = res;
        state_nxt    = ST_IDLE;
      end else begin
        pend_nxt  = res;
        state_nxt = ST_HOLD;
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= cnt_t'(SHARED_CTX);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_r      <= chk_nxt;
    id_r       <= id_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The free count can never exceed the number of non-shared contexts.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(SHARED_CTX))
    else $error("free count above the number of allocatable contexts");

  // A result is parked only while the output register is occupied.
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("result parked while the output register is empty");

  // The bitmap is written only by the scan or the free check.
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == ST_SCAN || state_r == ST_FREE_CHK))
    else $error("bitmap written outside an update cycle");

  // A successful allocation never hands out the shared context.
  a_no_shared_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && wr.en) |-> (res.granted_id != ID_W'(SHARED_CTX)))
    else $error("shared context granted as a private one");

endmodule
